[rtl/ttcb_pkg.sv]
// Shared types and constants of the text terminal character buffer.
package ttcb_pkg;

	localparam int unsigned S_DATA_W = 24;
	localparam int unsigned M_DATA_W = 24;

	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_RETURN    = 8'h0D;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	localparam logic KIND_PUT  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXEC   = 4'b0010,
		ST_SWEEP  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec_write;
		logic sweep_write;
		logic rd_issue;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_read;
		logic need_sweep;
		logic sweep_last;
		logic out_free;
	} sts_t;

endpackage

[rtl/ttcb_ctrl.sv]
// Controller state machine of the text terminal character buffer.
module ttcb_ctrl import ttcb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.is_read) begin
					cmd.rd_issue = 1'b1;
					state_d      = ST_FINISH;
				end else if (sts.need_sweep) begin
					state_d = ST_SWEEP;
				end else begin
					cmd.exec_write = 1'b1;
					if (sts.out_free) begin
						cmd.load_out = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SWEEP: begin
				cmd.sweep_write = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_EXEC;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/ttcb_dp.sv]
// Datapath of the text terminal character buffer: cursor, row rotation, cell store, output beat.
module ttcb_dp import ttcb_pkg::*; #(
	parameter int unsigned TEXT_ROWS = 25,
	parameter int unsigned TEXT_COLS = 80
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic                s_tuser,
	input  logic                m_tready,
	output logic                m_tvalid,
	output logic [M_DATA_W-1:0] m_tdata,
	input  cmd_t                cmd,
	output sts_t                sts
);

	localparam int unsigned RW    = $clog2(TEXT_ROWS);
	localparam int unsigned CW    = $clog2(TEXT_COLS + 1);
	localparam int unsigned CIW   = $clog2(TEXT_COLS);
	localparam int unsigned DEPTH = TEXT_ROWS * TEXT_COLS;
	localparam int unsigned AW    = $clog2(DEPTH);

	logic [7:0] in_char;
	logic [4:0] in_row;
	logic [6:0] in_col;

	logic [CW-1:0]        col_q;
	logic [RW-1:0]        row_q;
	logic [RW-1:0]        top_q;
	logic [TEXT_ROWS-1:0] row_valid_q;
	logic [CIW-1:0]       sweep_col_q;

	logic           plan_read_q;
	logic           plan_wr_q;
	logic           plan_bs_q;
	logic           plan_scr_q;
	logic           plan_ok_q;
	logic [RW-1:0]  plan_row_q;
	logic [CIW-1:0] plan_col_q;
	logic [7:0]     plan_data_q;

	logic           out_valid_q;
	logic [M_DATA_W-1:0] out_data_q;
	logic [7:0]     rdata_q;

	logic [CW-1:0]  nxt_col;
	logic [RW-1:0]  nxt_row;
	logic [RW-1:0]  nxt_top;
	logic           nxt_scr;
	logic           nxt_wr;
	logic           nxt_bs;
	logic [CIW-1:0] nxt_wcol;
	logic [7:0]     nxt_data;
	logic           rd_ok;
	logic [RW-1:0]  sel_row;
	logic [RW-1:0]  sel_top;
	logic [RW:0]    phys_sum;
	logic [RW-1:0]  phys_row;
	logic [CIW-1:0] acc_col;
	logic [AW-1:0]  addr;
	logic           we;
	logic [7:0]     wdata;
	logic [7:0]     rd_char;

	logic [7:0] mem [DEPTH];

	assign in_char = s_tdata[7:0];
	assign in_row  = s_tdata[12:8];
	assign in_col  = s_tdata[19:13];

	always_comb begin
		nxt_col  = col_q;
		nxt_row  = row_q;
		nxt_scr  = 1'b0;
		nxt_wr   = 1'b0;
		nxt_bs   = 1'b0;
		nxt_wcol = CIW'(col_q);
		nxt_data = in_char;
		if (s_tuser == KIND_PUT) begin
			case (in_char)
				CH_NUL: begin
				end
				CH_NEWLINE: begin
					nxt_col = '0;
					if (row_q == RW'(TEXT_ROWS - 1)) begin
						nxt_scr = 1'b1;
					end else begin
						nxt_row = row_q + RW'(1);
					end
				end
				CH_RETURN: begin
					nxt_col = '0;
				end
				CH_BACKSPACE: begin
					if (col_q != '0) begin
						nxt_col  = col_q - CW'(1);
						nxt_wcol = CIW'(col_q - CW'(1));
						nxt_wr   = 1'b1;
						nxt_bs   = 1'b1;
						nxt_data = CH_SPACE;
					end
				end
				default: begin
					nxt_wr = 1'b1;
					if (col_q == CW'(TEXT_COLS)) begin
						nxt_wcol = '0;
						nxt_col  = CW'(1);
						if (row_q == RW'(TEXT_ROWS - 1)) begin
							nxt_scr = 1'b1;
						end else begin
							nxt_row = row_q + RW'(1);
						end
					end else begin
						nxt_col = col_q + CW'(1);
					end
				end
			endcase
		end
	end

	always_comb begin
		nxt_top = top_q;
		if (nxt_scr) begin
			nxt_top = (top_q == RW'(TEXT_ROWS - 1)) ? '0 : top_q + RW'(1);
		end
		rd_ok   = (32'(in_row) < TEXT_ROWS) && (32'(in_col) < TEXT_COLS);
		sel_row = (s_tuser == KIND_READ) ? RW'(in_row) : nxt_row;
		sel_top = (s_tuser == KIND_READ) ? top_q : nxt_top;
		phys_sum = {1'b0, sel_row} + {1'b0, sel_top};
		if (phys_sum >= (RW+1)'(TEXT_ROWS)) begin
			phys_row = RW'(phys_sum - (RW+1)'(TEXT_ROWS));
		end else begin
			phys_row = RW'(phys_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			top_q       <= '0;
			row_valid_q <= '0;
			sweep_col_q <= '0;
			plan_read_q <= 1'b0;
			plan_wr_q   <= 1'b0;
			plan_bs_q   <= 1'b0;
			plan_scr_q  <= 1'b0;
			plan_ok_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				col_q       <= nxt_col;
				row_q       <= nxt_row;
				top_q       <= nxt_top;
				plan_read_q <= (s_tuser == KIND_READ);
				plan_wr_q   <= nxt_wr;
				plan_bs_q   <= nxt_bs;
				plan_scr_q  <= nxt_scr;
				plan_ok_q   <= rd_ok;
				if (nxt_scr) begin
					row_valid_q[top_q] <= 1'b0;
				end
			end
			if (cmd.sweep_write) begin
				if (sweep_col_q == CIW'(TEXT_COLS - 1)) begin
					sweep_col_q             <= '0;
					row_valid_q[plan_row_q] <= 1'b1;
				end else begin
					sweep_col_q <= sweep_col_q + CIW'(1);
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			plan_row_q  <= phys_row;
			plan_col_q  <= (s_tuser == KIND_READ) ? CIW'(in_col) : nxt_wcol;
			plan_data_q <= nxt_data;
		end
	end

	assign acc_col = cmd.sweep_write ? sweep_col_q : plan_col_q;
	assign addr    = AW'(32'(plan_row_q) * TEXT_COLS + 32'(acc_col));
	assign we      = cmd.sweep_write
		|| (cmd.exec_write && plan_wr_q && row_valid_q[plan_row_q]);
	assign wdata   = cmd.sweep_write ? CH_SPACE : plan_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (cmd.rd_issue && plan_ok_q) begin
			rdata_q <= mem[addr];
		end
	end

	always_comb begin
		rd_char = 8'h00;
		if (plan_read_q && plan_ok_q) begin
			rd_char = row_valid_q[plan_row_q] ? rdata_q : CH_SPACE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= {3'b000, plan_scr_q && !plan_read_q, 5'(row_q), 7'(col_q), rd_char};
		end
	end

	assign sts.is_read    = plan_read_q;
	assign sts.need_sweep = plan_wr_q && !plan_bs_q && !row_valid_q[plan_row_q];
	assign sts.sweep_last = (sweep_col_q == CIW'(TEXT_COLS - 1));
	assign sts.out_free   = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

[rtl/text_terminal_char_buffer.sv]
// Top level of the text terminal character buffer.
//
// channel  dir  tdata (low bit up)                                  tuser
// s        in   char_code[7:0] read_row[12:8] read_col[19:13] pad   kind
// m        out  cell_char[7:0] cursor_column[14:8] cursor_line[19:15]
//               did_scroll[20] pad                                  -
//
// A put runs ST_IDLE then ST_EXEC; a read adds ST_FINISH (registered cell store read).
// A character write into a row marked blank first fills that row with spaces.
// Reset homes the cursor and marks every row blank; there is no clearing pass.
// Scroll rotates the row base and marks the recycled row blank, at no extra cost.
// A stalled output holds the next result until m_tready; one beat is taken meanwhile.
module text_terminal_char_buffer import ttcb_pkg::*; #(
	parameter int unsigned TEXT_ROWS = 25,
	parameter int unsigned TEXT_COLS = 80
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // char_code, read_row, read_col
	input  logic                s_tuser,  // kind
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata   // cell_char, cursor_column, cursor_line, did_scroll
);

	cmd_t cmd;
	sts_t sts;

	ttcb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ttcb_dp #(
		.TEXT_ROWS (TEXT_ROWS),
		.TEXT_COLS (TEXT_COLS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

[rtl/ttcb_chk.sv]
// Port checker of the text terminal character buffer and its bind.
module ttcb_chk import ttcb_pkg::*; #(
	parameter int unsigned TEXT_ROWS = 25,
	parameter int unsigned TEXT_COLS = 80
) (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [S_DATA_W-1:0] s_tdata,
	input logic                s_tuser,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (TEXT_ROWS <= 32) |-> 32'(m_tdata[19:15]) < TEXT_ROWS)
		else $error("cursor line out of range");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (TEXT_COLS <= 127) |-> 32'(m_tdata[14:8]) <= TEXT_COLS)
		else $error("cursor column out of range");

	a_scroll_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[20] |-> m_tdata[19:15] == 5'(TEXT_ROWS - 1) && m_tdata[7:0] == 8'h00)
		else $error("scroll beat not on bottom line");

	a_beat_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:21] == 3'b000)
		else $error("output pad bits set");

endmodule

bind text_terminal_char_buffer ttcb_chk #(
	.TEXT_ROWS (TEXT_ROWS),
	.TEXT_COLS (TEXT_COLS)
) u_chk (.*);
